>>> rtl/pidtf_pkg.sv
package pidtf_pkg;

  // sample width default
  localparam int SampleWidth = 32;

  // datapath widths that follow from the sample width
  localparam int NumW = (SampleWidth + 74 > 98) ? SampleWidth + 74 : 98;
  localparam int OpW  = (SampleWidth + 2 > 33) ? SampleWidth + 2 : 33;

  // configuration port
  localparam int CfgW    = 32;
  localparam int CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PROP_GAIN     = 3'd0,
    CFG_INTEG_GAIN    = 3'd1,
    CFG_DERIV_GAIN    = 3'd2,
    CFG_DERIV_BW      = 3'd3,
    CFG_SAMPLE_PERIOD = 3'd4
  } cfg_idx_e;

  localparam logic [CfgW-1:0] PropGainRst   = 32'd65536;
  localparam logic [CfgW-1:0] IntegGainRst  = 32'd0;
  localparam logic [CfgW-1:0] DerivGainRst  = 32'd0;
  localparam logic [CfgW-1:0] DerivBwRst    = 32'd409600;
  localparam logic [CfgW-1:0] SamplePerRst  = 32'd4294967;

  // coefficient formats
  localparam int DenW   = 54;
  localparam int NacW   = 55;
  localparam int TaW    = 69;
  localparam int TbW    = 68;
  localparam int K3W    = 65;
  localparam int S28W   = 65;

  // fixed-point shifts
  localparam int GtProdW      = 64;
  localparam int GtShift      = 12;
  localparam int KScale       = 12;
  localparam int DenBaseShift = 34;
  localparam int TaShift      = 28;
  localparam int TbProdW      = 96;
  localparam int TbShift1     = 32;
  localparam int TbShift2     = 28;
  localparam int K3Shift      = 6;
  localparam int Y1Shift      = 35;

  // multiplier digit size
  localparam int MulDigitW = 12;

endpackage

>>> rtl/pidtf_if.sv
interface pidtf_in_if #(
  parameter int SampleWidth = pidtf_pkg::SampleWidth
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SampleWidth-1:0] error_in;

  modport source (output valid, output error_in, input ready);
  modport sink (input valid, input error_in, output ready);
endinterface

interface pidtf_out_if #(
  parameter int SampleWidth = pidtf_pkg::SampleWidth
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SampleWidth-1:0] drive_out;
  logic                          clipped;

  modport source (output valid, output drive_out, output clipped, input ready);
  modport sink (input valid, input drive_out, input clipped, output ready);
endinterface

>>> rtl/pidtf_mul.sv
module pidtf_mul #(
  parameter int NumW = pidtf_pkg::NumW,
  parameter int OpW  = pidtf_pkg::OpW
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic signed [NumW-1:0] a_i,
  input  logic signed [OpW-1:0]  b_i,
  output logic                   done_o,
  output logic signed [NumW-1:0] p_o
);

  localparam int DigW = pidtf_pkg::MulDigitW;

  logic                   busy_q, fin_q, done_q;
  logic signed [NumW-1:0] a_q, acc_q, p_q;
  logic [OpW-1:0]         b_q;
  logic                   neg_q;

  logic [OpW-1:0]         b_mag;
  logic [OpW-1:0]         b_next;
  logic signed [NumW-1:0] pp;
  logic                   last_digit;

  assign b_mag      = b_i[OpW-1] ? (~b_i + OpW'(1)) : b_i;
  assign b_next     = b_q >> DigW;
  assign last_digit = (b_next == '0);
  assign pp         = a_q * $signed({1'b0, b_q[DigW-1:0]});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= fin_q;
      fin_q  <= busy_q && last_digit;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && last_digit) begin
        busy_q <= 1'b0;
      end
    end
  end

  // one digit of b per cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_mag;
      neg_q <= b_i[OpW-1];
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= acc_q + pp;
      a_q   <= a_q << DigW;
      b_q   <= b_next;
    end
    if (fin_q) begin
      p_q <= neg_q ? (~acc_q + NumW'(1)) : acc_q;
    end
  end

  assign done_o = done_q;
  assign p_o    = p_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q && !fin_q)
    else $error("multiplier started while busy");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("multiplier done longer than one cycle");

endmodule

>>> rtl/pidtf_div.sv
module pidtf_div #(
  parameter int NumW        = pidtf_pkg::NumW,
  parameter int SampleWidth = pidtf_pkg::SampleWidth,
  parameter int DenW        = pidtf_pkg::DenW
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [NumW-1:0]        mag_i,
  input  logic [DenW-1:0]        den_i,
  output logic                   done_o,
  output logic [SampleWidth-1:0] quot_o,
  output logic                   ovf_o
);

  localparam int CntW = $clog2(SampleWidth + 1);
  localparam int HiW  = NumW - SampleWidth;

  logic                   busy_q, done_q;
  logic [CntW-1:0]        cnt_q;
  logic [DenW-1:0]        rem_q;
  logic [SampleWidth-1:0] low_q, q_q;
  logic                   ovf_q;

  logic [HiW-1:0]  mag_hi;
  logic            ovf_start;
  logic [DenW:0]   trial, diff;
  logic            ge;

  assign mag_hi    = mag_i[NumW-1:SampleWidth];
  assign ovf_start = mag_hi >= {{(HiW-DenW){1'b0}}, den_i};
  assign trial     = {rem_q, low_q[SampleWidth-1]};
  assign diff      = trial - {1'b0, den_i};
  assign ge        = trial >= {1'b0, den_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= !ovf_start;
        done_q <= ovf_start;
        cnt_q  <= CntW'(SampleWidth);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // restoring division, one quotient bit per cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ovf_q <= ovf_start;
      rem_q <= mag_hi[DenW-1:0];
      low_q <= mag_i[SampleWidth-1:0];
    end else if (busy_q) begin
      rem_q <= ge ? diff[DenW-1:0] : trial[DenW-1:0];
      low_q <= low_q << 1;
      q_q   <= {q_q[SampleWidth-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = q_q;
  assign ovf_o  = ovf_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider started while busy");

endmodule

>>> rtl/pid_tustin_filtered_derivative_unit.sv
// each request runs through the shared multiplier and then the divider, one request at a time
// after reset or a config write the first request adds 7 multiplies to recompute the coefficients
// a new request is accepted only in the idle state, once the previous result is in the output register
// reset: config registers to their defaults, sample and output history cleared
module pid_tustin_filtered_derivative_unit #(
  parameter int SampleWidth = pidtf_pkg::SampleWidth
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [pidtf_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [pidtf_pkg::CfgW-1:0]       cfg_data_i,
  pidtf_in_if.sink                         req_i,
  pidtf_out_if.source                      rsp_o
);

  localparam int W    = SampleWidth;
  localparam int NumW = (SampleWidth + 74 > 98) ? SampleWidth + 74 : 98;
  localparam int OpW  = (SampleWidth + 2 > 33) ? SampleWidth + 2 : 33;
  localparam int DenW = pidtf_pkg::DenW;
  localparam int NacW = pidtf_pkg::NacW;
  localparam int TaW  = pidtf_pkg::TaW;
  localparam int TbW  = pidtf_pkg::TbW;
  localparam int K3W  = pidtf_pkg::K3W;
  localparam int S28W = pidtf_pkg::S28W;
  localparam int KSc  = pidtf_pkg::KScale;

  typedef enum logic [14:0] {
    ST_IDLE = 15'h0001,
    ST_GT   = 15'h0002,
    ST_KPG  = 15'h0004,
    ST_S28T = 15'h0008,
    ST_KIG  = 15'h0010,
    ST_KIGT = 15'h0020,
    ST_TB   = 15'h0040,
    ST_KDG  = 15'h0080,
    ST_EA   = 15'h0100,
    ST_EB   = 15'h0200,
    ST_EC   = 15'h0400,
    ST_ED   = 15'h0800,
    ST_MAG  = 15'h1000,
    ST_DIV  = 15'h2000,
    ST_OUT  = 15'h4000
  } state_e;

  state_e state_q, state_d;

  logic signed [31:0]     kp_q, ki_q, kd_q;
  logic [31:0]            g_q, t_q;
  logic                   dirty_q;

  logic signed [W-1:0]    u_q, u1_q, u2_q, y1_q, y2_q;
  logic [DenW-1:0]        den_q;
  logic signed [NacW-1:0] nac_q;
  logic signed [TaW-1:0]  ta_q;
  logic signed [TbW-1:0]  tb_q;
  logic signed [K3W-1:0]  k3_q;
  logic signed [NumW-1:0] num_q;
  logic                   neg_q;

  logic                   out_valid_q;
  logic signed [W-1:0]    out_drive_q;
  logic                   out_clip_q;

  logic                   mul_start, mul_done;
  logic signed [NumW-1:0] mul_a, mres;
  logic signed [OpW-1:0]  mul_b;
  logic                   div_start, div_done, div_ovf;
  logic [NumW-1:0]        div_mag;
  logic [W-1:0]           div_quot;

  logic                   accept, slot_free, emit;
  logic signed [W-1:0]    u_cur;
  logic signed [OpW-1:0]  u_x, u1_x, u2_x, e1, e2, e3, b_t, b_g, b_y2;
  logic signed [S28W-1:0] s28;
  logic signed [K3W-1:0]  k3_sum;
  logic [DenW-2:0]        gt2;
  logic [DenW-1:0]        den_new;
  logic [NacW-1:0]        nac_new;
  logic signed [NumW-1:0] a_g, a_kp, a_ki, a_kd, a_s28, a_kigt, a_ta, a_tb, a_k3, a_nac;
  logic [W-1:0]           lim, res;
  logic                   clip;
  logic signed [W-1:0]    y;

  assign accept    = req_i.valid && req_i.ready;
  assign slot_free = !out_valid_q || rsp_o.ready;
  assign emit      = (state_q == ST_OUT) && slot_free;

  // error terms
  assign u_cur = (state_q == ST_IDLE) ? req_i.error_in : u_q;
  assign u_x   = {{(OpW-W){u_cur[W-1]}}, u_cur};
  assign u1_x  = {{(OpW-W){u1_q[W-1]}}, u1_q};
  assign u2_x  = {{(OpW-W){u2_q[W-1]}}, u2_q};
  assign e1    = u_x - u2_x;
  assign e2    = u_x + (u1_x <<< 1) + u2_x;
  assign e3    = u_x - (u1_x <<< 1) + u2_x;
  assign b_t   = {{(OpW-32){1'b0}}, t_q};
  assign b_g   = {{(OpW-32){1'b0}}, g_q};
  assign b_y2  = {{(OpW-W){y2_q[W-1]}}, y2_q};

  // coefficient terms from the multiplier result
  assign s28     = mres[S28W-1:0] + {{(S28W-32-KSc){ki_q[31]}}, ki_q, {KSc{1'b0}}};
  assign k3_sum  = mres[K3W-1:0] + {{(K3W-32-KSc){kp_q[31]}}, kp_q, {KSc{1'b0}}};
  assign gt2     = {mres[pidtf_pkg::GtProdW-1:pidtf_pkg::GtShift], 1'b0};
  assign den_new = {1'b0, gt2} + (DenW'(1) << pidtf_pkg::DenBaseShift);
  assign nac_new = {2'b00, gt2} - (NacW'(1) << pidtf_pkg::DenBaseShift);

  assign a_g    = {{(NumW-32){1'b0}}, g_q};
  assign a_kp   = {{(NumW-32){kp_q[31]}}, kp_q};
  assign a_ki   = {{(NumW-32){ki_q[31]}}, ki_q};
  assign a_kd   = {{(NumW-32){kd_q[31]}}, kd_q};
  assign a_s28  = {{(NumW-S28W){s28[S28W-1]}}, s28};
  assign a_kigt = {{(NumW-pidtf_pkg::TbProdW+pidtf_pkg::TbShift1){mres[pidtf_pkg::TbProdW-1]}},
                   mres[pidtf_pkg::TbProdW-1:pidtf_pkg::TbShift1]};
  assign a_ta   = {{(NumW-TaW-1){ta_q[TaW-1]}}, ta_q, 1'b0};
  assign a_tb   = {{(NumW-TbW){tb_q[TbW-1]}}, tb_q};
  assign a_k3   = {{(NumW-K3W-pidtf_pkg::K3Shift){k3_q[K3W-1]}}, k3_q,
                   {pidtf_pkg::K3Shift{1'b0}}};
  assign a_nac  = {{(NumW-NacW){nac_q[NacW-1]}}, nac_q};

  // rounding: magnitude plus half the denominator
  assign div_mag = (num_q ^ {NumW{num_q[NumW-1]}})
                 + {{(NumW-DenW+1){1'b0}}, den_q[DenW-1:1]}
                 + {{(NumW-1){1'b0}}, num_q[NumW-1]};

  // saturation
  assign lim  = {1'b0, {(W-1){1'b1}}} + W'(neg_q);
  assign clip = div_ovf || (div_quot > lim);
  assign res  = clip ? lim : div_quot;
  assign y    = neg_q ? (~res + W'(1)) : res;

  always_comb begin
    state_d   = state_q;
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          mul_start = 1'b1;
          if (dirty_q) begin
            mul_a   = a_g;
            mul_b   = b_t;
            state_d = ST_GT;
          end else begin
            mul_a   = a_ta;
            mul_b   = e1;
            state_d = ST_EA;
          end
        end
      end
      ST_GT: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a     = a_kp;
          mul_b     = b_g;
          state_d   = ST_KPG;
        end
      end
      ST_KPG: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a     = a_s28;
          mul_b     = b_t;
          state_d   = ST_S28T;
        end
      end
      ST_S28T: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a     = a_ki;
          mul_b     = b_g;
          state_d   = ST_KIG;
        end
      end
      ST_KIG: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a     = mres;
          mul_b     = b_t;
          state_d   = ST_KIGT;
        end
      end
      ST_KIGT: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a     = a_kigt;
          mul_b     = b_t;
          state_d   = ST_TB;
        end
      end
      ST_TB: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a     = a_kd;
          mul_b     = b_g;
          state_d   = ST_KDG;
        end
      end
      ST_KDG: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a     = a_ta;
          mul_b     = e1;
          state_d   = ST_EA;
        end
      end
      ST_EA: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a     = a_tb;
          mul_b     = e2;
          state_d   = ST_EB;
        end
      end
      ST_EB: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a     = a_k3;
          mul_b     = e3;
          state_d   = ST_EC;
        end
      end
      ST_EC: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a     = a_nac;
          mul_b     = b_y2;
          state_d   = ST_ED;
        end
      end
      ST_ED: begin
        if (mul_done) begin
          state_d = ST_MAG;
        end
      end
      ST_MAG: begin
        div_start = 1'b1;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      kp_q        <= pidtf_pkg::PropGainRst;
      ki_q        <= pidtf_pkg::IntegGainRst;
      kd_q        <= pidtf_pkg::DerivGainRst;
      g_q         <= pidtf_pkg::DerivBwRst;
      t_q         <= pidtf_pkg::SamplePerRst;
      dirty_q     <= 1'b1;
      out_valid_q <= 1'b0;
      u1_q        <= '0;
      u2_q        <= '0;
      y1_q        <= '0;
      y2_q        <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        dirty_q <= 1'b1;
        case (cfg_idx_i)
          pidtf_pkg::CFG_PROP_GAIN:     kp_q <= cfg_data_i;
          pidtf_pkg::CFG_INTEG_GAIN:    ki_q <= cfg_data_i;
          pidtf_pkg::CFG_DERIV_GAIN:    kd_q <= cfg_data_i;
          pidtf_pkg::CFG_DERIV_BW:      g_q  <= cfg_data_i;
          pidtf_pkg::CFG_SAMPLE_PERIOD: t_q  <= cfg_data_i;
          default: ;
        endcase
      end else if (accept) begin
        dirty_q <= 1'b0;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
        u2_q        <= u1_q;
        u1_q        <= u_q;
        y2_q        <= y1_q;
        y1_q        <= y;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          u_q   <= req_i.error_in;
          num_q <= {{(NumW-W-pidtf_pkg::Y1Shift){y1_q[W-1]}}, y1_q,
                    {pidtf_pkg::Y1Shift{1'b0}}};
        end
      end
      ST_GT: begin
        if (mul_done) begin
          den_q <= den_new;
          nac_q <= nac_new;
        end
      end
      ST_S28T: begin
        if (mul_done) begin
          ta_q <= mres[pidtf_pkg::TaShift+TaW-1:pidtf_pkg::TaShift];
        end
      end
      ST_TB: begin
        if (mul_done) begin
          tb_q <= mres[pidtf_pkg::TbShift2+TbW-1:pidtf_pkg::TbShift2];
        end
      end
      ST_KDG: begin
        if (mul_done) begin
          k3_q <= k3_sum;
        end
      end
      ST_EA, ST_EB, ST_EC, ST_ED: begin
        if (mul_done) begin
          num_q <= num_q + mres;
        end
      end
      ST_MAG: begin
        neg_q <= num_q[NumW-1];
      end
      default: ;
    endcase
    if (emit) begin
      out_drive_q <= y;
      out_clip_q  <= clip;
    end
  end

  pidtf_mul #(
    .NumW (NumW),
    .OpW  (OpW)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .p_o     (mres)
  );

  pidtf_div #(
    .NumW        (NumW),
    .SampleWidth (SampleWidth),
    .DenW        (DenW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .mag_i   (div_mag),
    .den_i   (den_q),
    .done_o  (div_done),
    .quot_o  (div_quot),
    .ovf_o   (div_ovf)
  );

  assign req_i.ready     = (state_q == ST_IDLE);
  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.drive_out = out_drive_q;
  assign rsp_o.clipped   = out_clip_q;

  a_clip_at_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_clip_q |->
      out_drive_q == {1'b0, {(W-1){1'b1}}} || out_drive_q == {1'b1, {(W-1){1'b0}}})
    else $error("clipped output not at a rail");

endmodule

>>> bench/tb_pid_tustin_filtered_derivative_unit.sv
`timescale 1ns / 1ps

module tb_pid_tustin_filtered_derivative_unit;

  localparam int SampleWidth = pidtf_pkg::SampleWidth;
  localparam int CfgW = pidtf_pkg::CfgW;
  localparam int CfgIdxW = pidtf_pkg::CfgIdxW;
  localparam int CycleLimit = 1000000;
  localparam int NumCfgRegs = 5;
  localparam int DrainCycles = 200;
  localparam int RandPhases = 12;
  localparam int ItemsPerPhase = 38;
  localparam int MaxPrinted = 40;
  localparam logic signed [127:0] One = 128'sd1;

  typedef enum int {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_e;

  typedef enum int {
    GAINS_TYPICAL,
    GAINS_WILD,
    GAINS_EXTREME
  } gain_kind_e;

  typedef struct packed {
    logic [SampleWidth-1:0] drive_out;
    logic                   clipped;
  } drive_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx = '0;
  logic [CfgW-1:0] cfg_data = '0;
  logic req_valid = 1'b0;
  logic [SampleWidth-1:0] req_data = '0;
  logic req_taken = 1'b0;
  logic rsp_ready = 1'b0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int fail_cnt = 0;

  logic [SampleWidth-1:0] error_samples[$];
  drive_t drive_expected[$];
  logic [SampleWidth-1:0] last_sample = '0;

  // controller model state
  logic [CfgW-1:0] kp_reg = pidtf_pkg::PropGainRst;
  logic [CfgW-1:0] ki_reg = pidtf_pkg::IntegGainRst;
  logic [CfgW-1:0] kd_reg = pidtf_pkg::DerivGainRst;
  logic [CfgW-1:0] bw_reg = pidtf_pkg::DerivBwRst;
  logic [CfgW-1:0] period_reg = pidtf_pkg::SamplePerRst;
  logic signed [SampleWidth-1:0] hist_in1 = '0;
  logic signed [SampleWidth-1:0] hist_in2 = '0;
  logic signed [SampleWidth-1:0] hist_out1 = '0;
  logic signed [SampleWidth-1:0] hist_out2 = '0;

  pidtf_in_if req_if ();
  pidtf_out_if rsp_if ();

  assign req_if.valid = req_valid;
  assign req_if.error_in = req_data;
  assign rsp_if.ready = rsp_ready;

  pid_tustin_filtered_derivative_unit dut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .req_i     (req_if),
    .rsp_o     (rsp_if)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic drive_t compute_drive(input logic signed [SampleWidth-1:0] u);
    logic signed [127:0] kp, ki, kd, gw, tw, uw, u1, u2, y1, y2;
    logic signed [127:0] gt, den, acoef, s28, ta, tb, k3, num, mag, q, lim, res;
    logic neg, clip;
    drive_t r;
    kp = $signed(kp_reg);
    ki = $signed(ki_reg);
    kd = $signed(kd_reg);
    gw = {96'd0, bw_reg};
    tw = {96'd0, period_reg};
    uw = u;
    u1 = hist_in1;
    u2 = hist_in2;
    y1 = hist_out1;
    y2 = hist_out2;
    gt = (gw * tw) >>> pidtf_pkg::GtShift;
    den = (One <<< pidtf_pkg::DenBaseShift) + 2 * gt;
    acoef = (One <<< pidtf_pkg::DenBaseShift) - 2 * gt;
    s28 = kp * gw + (ki <<< pidtf_pkg::KScale);
    ta = (s28 * tw) >>> pidtf_pkg::TaShift;
    num = (ta * (uw - u2)) <<< 1;
    tb = ((ki * gw) * tw) >>> pidtf_pkg::TbShift1;
    tb = (tb * tw) >>> pidtf_pkg::TbShift2;
    num = num + tb * (uw + 2 * u1 + u2);
    k3 = kd * gw + (kp <<< pidtf_pkg::KScale);
    num = num + ((k3 * (uw - 2 * u1 + u2)) <<< pidtf_pkg::K3Shift);
    num = num - acoef * y2 + (y1 <<< pidtf_pkg::Y1Shift);
    // round half away from zero on the magnitude
    neg = num[127];
    mag = neg ? -num : num;
    mag = mag + (den >>> 1);
    q = mag / den;
    lim = neg ? (One <<< (SampleWidth - 1)) : (One <<< (SampleWidth - 1)) - One;
    clip = q > lim;
    res = clip ? lim : q;
    if (neg) begin
      res = -res;
    end
    hist_in2 = hist_in1;
    hist_in1 = u;
    hist_out2 = hist_out1;
    hist_out1 = res[SampleWidth-1:0];
    r.drive_out = res[SampleWidth-1:0];
    r.clipped = clip;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    if (fail_cnt < MaxPrinted) begin
      $display("%0t mismatch: %s", $realtime, msg);
    end
    fail_cnt = fail_cnt + 1;
  endtask

  // request driver
  always @(negedge clk) begin
    if (!rst_n) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_taken) begin
      if (error_samples.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        req_valid <= 1'b1;
        req_data <= error_samples[0];
      end else begin
        req_valid <= 1'b0;
        req_data <= $urandom();
      end
    end
  end

  always @(posedge clk) begin
    req_taken <= req_valid && req_if.ready;
    if (rst_n && req_valid && req_if.ready) begin
      drive_expected.push_back(compute_drive(req_if.error_in));
      void'(error_samples.pop_front());
    end
  end

  always @(negedge clk) begin
    rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // result monitor
  always @(posedge clk) begin
    drive_t exp_d;
    if (rst_n && rsp_if.valid && rsp_ready) begin
      if (drive_expected.size() == 0) begin
        report_mismatch($sformatf("unexpected result drive_out=%h clipped=%b",
                                  rsp_if.drive_out, rsp_if.clipped));
      end else begin
        exp_d = drive_expected.pop_front();
        if (rsp_if.drive_out !== exp_d.drive_out) begin
          report_mismatch($sformatf("drive_out got %h exp %h", rsp_if.drive_out,
                                    exp_d.drive_out));
        end
        if (rsp_if.clipped !== exp_d.clipped) begin
          report_mismatch($sformatf("clipped got %b exp %b", rsp_if.clipped,
                                    exp_d.clipped));
        end
      end
    end
  end

  initial begin
    int cycles;
    for (cycles = 0; cycles < CycleLimit; cycles++) begin
      @(posedge clk);
    end
    $display("pid_tustin_filtered_derivative_unit test failed");
    $finish;
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    case (idx)
      pidtf_pkg::CFG_PROP_GAIN: kp_reg = val;
      pidtf_pkg::CFG_INTEG_GAIN: ki_reg = val;
      pidtf_pkg::CFG_DERIV_GAIN: kd_reg = val;
      pidtf_pkg::CFG_DERIV_BW: bw_reg = val;
      pidtf_pkg::CFG_SAMPLE_PERIOD: period_reg = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_gains(input logic [CfgW-1:0] kp, input logic [CfgW-1:0] ki,
                            input logic [CfgW-1:0] kd, input logic [CfgW-1:0] bw,
                            input logic [CfgW-1:0] period);
    write_reg(pidtf_pkg::CFG_PROP_GAIN, kp);
    write_reg(pidtf_pkg::CFG_INTEG_GAIN, ki);
    write_reg(pidtf_pkg::CFG_DERIV_GAIN, kd);
    write_reg(pidtf_pkg::CFG_DERIV_BW, bw);
    write_reg(pidtf_pkg::CFG_SAMPLE_PERIOD, period);
  endtask

  task automatic wait_drained();
    while (error_samples.size() != 0 || drive_expected.size() != 0) begin
      @(posedge clk);
    end
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic set_idling(input idle_mode_e mode);
    send_idle_pct = (mode == IDLE_SEND) ? 49 : (mode == IDLE_BOTH) ? 10 : 0;
    recv_stall_pct = (mode == IDLE_RECV) ? 49 : (mode == IDLE_BOTH) ? 10 : 0;
  endtask

  function automatic logic [CfgW-1:0] pick_signed_extreme();
    case ($urandom_range(0, 3))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      default: return 32'hffff_ffff;
    endcase
  endfunction

  function automatic logic [CfgW-1:0] pick_unsigned_extreme();
    case ($urandom_range(0, 2))
      0: return 32'h0000_0000;
      1: return 32'hffff_ffff;
      default: return 32'h0000_0001;
    endcase
  endfunction

  // gains within +-4.0, bandwidth up to 2000 rad/s, period up to 1/16 s
  function automatic logic [CfgW-1:0] typical_gain();
    return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
  endfunction

  function automatic logic [SampleWidth-1:0] next_error();
    logic [SampleWidth-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom();
      4, 5, 6: v = $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      7: v = pick_signed_extreme();
      8: v = last_sample;
      default: v = 32'h1 << $urandom_range(0, SampleWidth - 1);
    endcase
    last_sample = v;
    return v;
  endfunction

  initial begin
    int p, i, k;
    gain_kind_e kind;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // reset gains: zero, unit steps and alternating full-scale samples
    set_idling(IDLE_NONE);
    error_samples.push_back(32'h0000_0000);
    error_samples.push_back(32'h0000_0001);
    error_samples.push_back(32'hffff_ffff);
    error_samples.push_back(32'h7fff_ffff);
    error_samples.push_back(32'h8000_0000);
    error_samples.push_back(32'h7fff_ffff);
    error_samples.push_back(32'h8000_0000);
    error_samples.push_back(32'h0001_0000);
    error_samples.push_back(32'h0000_0000);
    error_samples.push_back(32'h0000_0000);
    wait_drained();

    // largest gains, bandwidth and period: saturation both ways
    load_gains(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    error_samples.push_back(32'h7fff_ffff);
    error_samples.push_back(32'h8000_0000);
    error_samples.push_back(32'h0000_0001);
    error_samples.push_back(32'h0000_0000);
    wait_drained();

    // most negative gains with zero bandwidth and period
    load_gains(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0000_0000, 32'h0000_0000);
    error_samples.push_back(32'h8000_0000);
    error_samples.push_back(32'h7fff_ffff);
    error_samples.push_back(32'h0000_0000);
    error_samples.push_back(32'hffff_ffff);
    wait_drained();

    // spare indexes must leave the gains alone
    load_gains(32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    for (k = NumCfgRegs; k < (1 << CfgIdxW); k++) begin
      write_reg(k[CfgIdxW-1:0], $urandom());
    end
    error_samples.push_back(32'h0000_8000);
    error_samples.push_back(32'hffff_8000);
    error_samples.push_back(32'h0000_0003);
    wait_drained();

    for (p = 0; p < RandPhases; p++) begin
      kind = gain_kind_e'(p % 3);
      case (kind)
        GAINS_TYPICAL: begin
          load_gains(typical_gain(), typical_gain(), typical_gain(),
                     $urandom_range(0, 4096 * 2000), $urandom_range(0, 32'h1000_0000));
        end
        GAINS_WILD: begin
          load_gains($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
        end
        default: begin
          load_gains(pick_signed_extreme(), pick_signed_extreme(), pick_signed_extreme(),
                     pick_unsigned_extreme(), pick_unsigned_extreme());
        end
      endcase
      if ($urandom_range(0, 3) == 0) begin
        write_reg(CfgIdxW'(NumCfgRegs +
                           $urandom_range(0, (1 << CfgIdxW) - NumCfgRegs - 1)),
                  $urandom());
      end
      set_idling(idle_mode_e'(p % 4));
      for (i = 0; i < ItemsPerPhase; i++) begin
        error_samples.push_back(next_error());
      end
      wait_drained();
    end

    if (fail_cnt == 0) begin
      $display("pid_tustin_filtered_derivative_unit test passed");
    end else begin
      $display("pid_tustin_filtered_derivative_unit test failed");
    end
    $finish;
  end

endmodule
